// ===== design/tda_pkg.sv =====
// Shared types and constants for the time-of-day arithmetic block.
`timescale 1ns / 1ps
`default_nettype none

package tda_pkg;

  // Request actions
  typedef enum logic [1:0] {
    ACT_SET = 2'd0,
    ACT_ADD = 2'd1,
    ACT_SUB = 2'd2,
    ACT_CMP = 2'd3
  } action_t;

  // Time base constants
  localparam logic [16:0] DAY_SECONDS   = 17'd86400;
  localparam logic [11:0] SECS_PER_HOUR = 12'd3600;
  localparam logic [5:0]  SIXTY         = 6'd60;
  localparam logic [4:0]  HOURS_PER_DAY = 5'd24;

  // Amount reduction: the amount is split into bytes, each byte is weighted by
  // 2^(8*i) mod one day, and the weighted sum is reduced by a reciprocal.
  localparam int          CHUNK_W    = 8;
  localparam int          MAX_CHUNKS = 8;
  localparam int          SUM_W      = 28;  // holds MAX_CHUNKS * 255 * 86399
  localparam int          QDAY_W     = 11;  // quotient of the sum by one day
  localparam logic [28:0] DAY_RECIP  = 29'd407226529;  // ceil(2^45 / 86400)
  localparam int          DAY_SHIFT  = 45;

  // Seconds-of-day to hour/minute/second by reciprocal multiply
  localparam logic [15:0] HOUR_RECIP = 16'd37283;  // ceil(2^27 / 3600)
  localparam logic [14:0] MIN_RECIP  = 15'd17477;  // ceil(2^20 / 60)

  // Queue between front and back
  localparam int QUEUE_DEPTH = 4;
  localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
  localparam int QUEUE_CNT_W = QUEUE_PTR_W + 1;

  // Input request fields other than the amount
  typedef struct packed {
    action_t     action;
    logic [4:0]  operand_hour;
    logic [5:0]  operand_minute;
    logic [5:0]  operand_second;
  } in_req_t;

  // Result fields
  typedef struct packed {
    logic [4:0]  hour_now;
    logic [5:0]  minute_now;
    logic [5:0]  second_now;
    logic        is_less;
    logic        is_equal;
    logic [16:0] difference;
  } rsp_t;

  // Classified command handed from front to back. The val fields hold the
  // clamped time for set, the amount mod one day for add/subtract and the
  // operand mod one day for compare, all as hour/minute/second.
  typedef struct packed {
    action_t     action;
    logic [4:0]  val_hour;
    logic [5:0]  val_minute;
    logic [5:0]  val_second;
    logic [4:0]  op_hour;
    logic [5:0]  op_minute;
    logic [5:0]  op_second;
  } cmd_t;

endpackage

`default_nettype wire

// ===== design/tda_front.sv =====
// Front pipeline: reduce amount or operand mod one day and split into h/m/s.
`timescale 1ns / 1ps
`default_nettype none

module tda_front #(
  parameter int AMOUNT_WIDTH = 32
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  tda_pkg::in_req_t        in_req,
  input  logic [AMOUNT_WIDTH-1:0] in_amount,
  output logic                    cmd_valid,
  input  logic                    cmd_ready,
  output tda_pkg::cmd_t           cmd
);

  localparam int NCHUNK    = (AMOUNT_WIDTH + tda_pkg::CHUNK_W - 1) / tda_pkg::CHUNK_W;
  localparam int AMT_PAD_W = NCHUNK * tda_pkg::CHUNK_W;
  localparam int PROD_W    = tda_pkg::CHUNK_W + 17;
  localparam int NSTAGE    = 7;

  typedef struct packed {
    tda_pkg::action_t action;
    logic [4:0]       op_hour;
    logic [5:0]       op_minute;
    logic [5:0]       op_second;
  } meta_t;

  // 2^(8*idx) mod one day, evaluated at elaboration
  function automatic logic [16:0] chunk_weight(input int idx);
    int w;
    w = 1;
    for (int k = 0; k < idx; k++) begin
      w = w * (1 << tda_pkg::CHUNK_W);
      while (w >= int'(tda_pkg::DAY_SECONDS)) begin
        w = w - int'(tda_pkg::DAY_SECONDS);
      end
    end
    return 17'(w);
  endfunction

  logic                    en;
  logic [AMT_PAD_W-1:0]    amt_pad;
  logic                    vld_r  [NSTAGE];
  meta_t                   meta_r [NSTAGE];

  logic [PROD_W-1:0]       prod_nxt [NCHUNK];
  logic [PROD_W-1:0]       prod_r   [NCHUNK];
  logic [16:0]             opnd_tot_nxt, opnd_tot_r;
  logic [tda_pkg::SUM_W-1:0] sum_nxt, sum_r, sum2_r;
  logic [16:0]             opnd_mod_nxt, opnd_mod_r, opnd_mod2_r;
  logic [tda_pkg::QDAY_W-1:0] q_nxt, q_r;
  logic [16:0]             amt_mod, v_nxt, v_r, v2_r;
  logic [31:0]             hprod_nxt, hprod_r;
  logic [4:0]              hr_nxt, hr_r, hr2_r;
  logic [11:0]             rem_nxt, rem_r, rem2_r;
  logic [25:0]             mprod_nxt, mprod_r;
  logic [5:0]              min_out, sec_out;

  // Advance the whole pipeline unless the last stage is blocked
  assign en       = !vld_r[NSTAGE-1] || cmd_ready;
  assign in_ready = en;
  assign amt_pad  = AMT_PAD_W'(in_amount);

  // Stage 0: weighted bytes and operand total
  for (genvar g = 0; g < NCHUNK; g++) begin : g_chunk
    localparam logic [16:0] WEIGHT = chunk_weight(g);
    assign prod_nxt[g] = PROD_W'(amt_pad[g*tda_pkg::CHUNK_W +: tda_pkg::CHUNK_W])
                         * PROD_W'(WEIGHT);
  end

  assign opnd_tot_nxt = 17'(in_req.operand_hour) * 17'(tda_pkg::SECS_PER_HOUR)
                      + 17'(in_req.operand_minute) * 17'(tda_pkg::SIXTY)
                      + 17'(in_req.operand_second);

  // Stage 1: sum of the weighted bytes, operand folded into one day
  always_comb begin
    sum_nxt = '0;
    for (int i = 0; i < NCHUNK; i++) begin
      sum_nxt = sum_nxt + tda_pkg::SUM_W'(prod_r[i]);
    end
  end

  assign opnd_mod_nxt = (opnd_tot_r >= tda_pkg::DAY_SECONDS) ?
                        17'(opnd_tot_r - tda_pkg::DAY_SECONDS) : opnd_tot_r;

  // Stage 2: quotient of the sum by one day
  assign q_nxt = tda_pkg::QDAY_W'((57'(sum_r) * 57'(tda_pkg::DAY_RECIP))
                                  >> tda_pkg::DAY_SHIFT);

  // Stage 3: remainder, pick the value to split
  assign amt_mod = 17'(sum2_r - tda_pkg::SUM_W'(q_r)
                              * tda_pkg::SUM_W'(tda_pkg::DAY_SECONDS));
  assign v_nxt   = (meta_r[2].action == tda_pkg::ACT_CMP) ? opnd_mod2_r : amt_mod;

  // Stage 4: hour product
  assign hprod_nxt = 32'(v_r) * 32'(tda_pkg::HOUR_RECIP);

  // Stage 5: hour and seconds within the hour
  assign hr_nxt  = hprod_r[31:27];
  assign rem_nxt = 12'(v2_r - 17'(hr_nxt) * 17'(tda_pkg::SECS_PER_HOUR));

  // Stage 6: minute product
  assign mprod_nxt = 26'(rem_r) * 26'(tda_pkg::MIN_RECIP);

  // Output: minute and second
  assign min_out = mprod_r[25:20];
  assign sec_out = 6'(rem2_r - 12'(min_out) * 12'(tda_pkg::SIXTY));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < NSTAGE; k++) begin
        vld_r[k] <= 1'b0;
      end
    end else if (en) begin
      vld_r[0] <= in_valid;
      for (int k = 1; k < NSTAGE; k++) begin
        vld_r[k] <= vld_r[k-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      meta_r[0] <= '{action:    in_req.action,
                     op_hour:   in_req.operand_hour,
                     op_minute: in_req.operand_minute,
                     op_second: in_req.operand_second};
      for (int k = 1; k < NSTAGE; k++) begin
        meta_r[k] <= meta_r[k-1];
      end
      for (int i = 0; i < NCHUNK; i++) begin
        prod_r[i] <= prod_nxt[i];
      end
      opnd_tot_r  <= opnd_tot_nxt;
      sum_r       <= sum_nxt;
      opnd_mod_r  <= opnd_mod_nxt;
      q_r         <= q_nxt;
      sum2_r      <= sum_r;
      opnd_mod2_r <= opnd_mod_r;
      v_r         <= v_nxt;
      hprod_r     <= hprod_nxt;
      v2_r        <= v_r;
      hr_r        <= hr_nxt;
      rem_r       <= rem_nxt;
      mprod_r     <= mprod_nxt;
      hr2_r       <= hr_r;
      rem2_r      <= rem_r;
    end
  end

  // Set loads the clamped operand; others carry the split value
  always_comb begin
    cmd.action    = meta_r[NSTAGE-1].action;
    cmd.op_hour   = meta_r[NSTAGE-1].op_hour;
    cmd.op_minute = meta_r[NSTAGE-1].op_minute;
    cmd.op_second = meta_r[NSTAGE-1].op_second;
    if (meta_r[NSTAGE-1].action == tda_pkg::ACT_SET) begin
      cmd.val_hour   = (meta_r[NSTAGE-1].op_hour < tda_pkg::HOURS_PER_DAY) ?
                       meta_r[NSTAGE-1].op_hour : '0;
      cmd.val_minute = (meta_r[NSTAGE-1].op_minute < tda_pkg::SIXTY) ?
                       meta_r[NSTAGE-1].op_minute : '0;
      cmd.val_second = (meta_r[NSTAGE-1].op_second < tda_pkg::SIXTY) ?
                       meta_r[NSTAGE-1].op_second : '0;
    end else begin
      cmd.val_hour   = hr2_r;
      cmd.val_minute = min_out;
      cmd.val_second = sec_out;
    end
  end

  assign cmd_valid = vld_r[NSTAGE-1];

endmodule

`default_nettype wire

// ===== design/tda_queue.sv =====
// Small FIFO of classified commands between front and back.
`timescale 1ns / 1ps
`default_nettype none

module tda_queue (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push_valid,
  output logic          push_ready,
  input  tda_pkg::cmd_t push_data,
  output logic          pop_valid,
  input  logic          pop_ready,
  output tda_pkg::cmd_t pop_data
);

  tda_pkg::cmd_t                    mem_r [tda_pkg::QUEUE_DEPTH];
  logic [tda_pkg::QUEUE_PTR_W-1:0]  wr_ptr_r, rd_ptr_r;
  logic [tda_pkg::QUEUE_CNT_W-1:0]  count_r;
  logic                             push, pop;

  assign push_ready = count_r != tda_pkg::QUEUE_CNT_W'(tda_pkg::QUEUE_DEPTH);
  assign pop_valid  = count_r != '0;
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;
  assign pop_data   = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      if (push && !pop) begin
        count_r <= count_r + 1'b1;
      end else if (pop && !push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

`default_nettype wire

// ===== design/tda_back.sv =====
// Back end: holds the time of day, applies commands, registers the result.
`timescale 1ns / 1ps
`default_nettype none

module tda_back (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          cmd_valid,
  output logic          cmd_ready,
  input  tda_pkg::cmd_t cmd,
  output logic          out_valid,
  input  logic          out_ready,
  output tda_pkg::rsp_t out_rsp
);

  logic [4:0]    hour_r, hour_nxt;
  logic [5:0]    min_r, min_nxt;
  logic [5:0]    sec_r, sec_nxt;
  logic          out_valid_r;
  tda_pkg::rsp_t out_rsp_r, rsp_nxt;
  logic          pop;

  // Mixed-radix add
  logic [6:0] s_sum, m_sum;
  logic [5:0] h_sum;
  logic       c0, c1;
  logic [4:0] add_h;
  logic [5:0] add_m, add_s;

  // Mixed-radix subtract, shared by subtract and compare
  logic       b0, b1, b2;
  logic [6:0] m_need;
  logic [5:0] h_need;
  logic [4:0] sub_h;
  logic [5:0] sub_m, sub_s;

  assign cmd_ready = !out_valid_r || out_ready;
  assign pop       = cmd_valid && cmd_ready;

  always_comb begin
    s_sum = 7'(sec_r) + 7'(cmd.val_second);
    c0    = s_sum >= 7'(tda_pkg::SIXTY);
    add_s = c0 ? 6'(s_sum - 7'(tda_pkg::SIXTY)) : 6'(s_sum);
    m_sum = 7'(min_r) + 7'(cmd.val_minute) + 7'(c0);
    c1    = m_sum >= 7'(tda_pkg::SIXTY);
    add_m = c1 ? 6'(m_sum - 7'(tda_pkg::SIXTY)) : 6'(m_sum);
    h_sum = 6'(hour_r) + 6'(cmd.val_hour) + 6'(c1);
    add_h = (h_sum >= 6'(tda_pkg::HOURS_PER_DAY)) ?
            5'(h_sum - 6'(tda_pkg::HOURS_PER_DAY)) : 5'(h_sum);
  end

  always_comb begin
    b0     = sec_r < cmd.val_second;
    sub_s  = b0 ? 6'(7'(sec_r) + 7'(tda_pkg::SIXTY) - 7'(cmd.val_second))
                : 6'(sec_r - cmd.val_second);
    m_need = 7'(cmd.val_minute) + 7'(b0);
    b1     = 7'(min_r) < m_need;
    sub_m  = b1 ? 6'(7'(min_r) + 7'(tda_pkg::SIXTY) - m_need)
                : 6'(7'(min_r) - m_need);
    h_need = 6'(cmd.val_hour) + 6'(b1);
    b2     = 6'(hour_r) < h_need;
    sub_h  = b2 ? 5'(6'(hour_r) + 6'(tda_pkg::HOURS_PER_DAY) - h_need)
                : 5'(6'(hour_r) - h_need);
  end

  always_comb begin
    hour_nxt = hour_r;
    min_nxt  = min_r;
    sec_nxt  = sec_r;
    rsp_nxt  = '0;
    unique case (cmd.action)
      tda_pkg::ACT_SET: begin
        hour_nxt = cmd.val_hour;
        min_nxt  = cmd.val_minute;
        sec_nxt  = cmd.val_second;
      end
      tda_pkg::ACT_ADD: begin
        hour_nxt = add_h;
        min_nxt  = add_m;
        sec_nxt  = add_s;
      end
      tda_pkg::ACT_SUB: begin
        hour_nxt = sub_h;
        min_nxt  = sub_m;
        sec_nxt  = sub_s;
      end
      tda_pkg::ACT_CMP: begin
        // Raw operand fields compare lexicographically as one packed word
        rsp_nxt.is_less    = {hour_r, min_r, sec_r}
                           < {cmd.op_hour, cmd.op_minute, cmd.op_second};
        rsp_nxt.is_equal   = {hour_r, min_r, sec_r}
                          == {cmd.op_hour, cmd.op_minute, cmd.op_second};
        rsp_nxt.difference = 17'(sub_h) * 17'(tda_pkg::SECS_PER_HOUR)
                           + 17'(sub_m) * 17'(tda_pkg::SIXTY)
                           + 17'(sub_s);
      end
      default: begin
      end
    endcase
    rsp_nxt.hour_now   = hour_nxt;
    rsp_nxt.minute_now = min_nxt;
    rsp_nxt.second_now = sec_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hour_r      <= '0;
      min_r       <= '0;
      sec_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (pop) begin
        hour_r <= hour_nxt;
        min_r  <= min_nxt;
        sec_r  <= sec_nxt;
      end
      if (cmd_ready) begin
        out_valid_r <= cmd_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      out_rsp_r <= rsp_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_rsp   = out_rsp_r;

endmodule

`default_nettype wire

// ===== design/time_of_day_arithmetic.sv =====
// Top level of the 24-hour time-of-day arithmetic block.
`timescale 1ns / 1ps
`default_nettype none

// Keeps a 24-hour time of day (hour, minute, second; zero after reset) and
// applies one request per accepted input: set, add seconds, subtract seconds
// or compare. Every request returns exactly one result carrying the time after
// the request; compare also returns less-than, equal and the stored time minus
// the operand in seconds modulo one day (those fields read zero otherwise).
// The block takes one request per clock cycle while the result side takes its
// results. A request passes through seven front stages that reduce the amount
// (or operand) modulo one day and split it into hour/minute/second, a
// four-entry queue that hands it over, and the back, which updates the stored
// time and registers the result. The state update in the back is the loop
// that sets the rate; the queue absorbs result stalls before the input side
// stalls. in_amount is AMOUNT_WIDTH bits wide
// (17 to 64).

module time_of_day_arithmetic #(
  parameter int AMOUNT_WIDTH = 32
) (
  input  logic                    clk,
  input  logic                    rst_n,
  // Input requests
  input  logic                    in_valid,
  output logic                    in_ready,
  input  tda_pkg::in_req_t        in_req,
  input  logic [AMOUNT_WIDTH-1:0] in_amount,
  // Results
  output logic                    out_valid,
  input  logic                    out_ready,
  output tda_pkg::rsp_t           out_rsp
);

  logic          f_valid, f_ready;
  tda_pkg::cmd_t f_cmd;
  logic          q_valid, q_ready;
  tda_pkg::cmd_t q_cmd;

  // Classify the request and precompute its operand as hour/minute/second
  tda_front #(
    .AMOUNT_WIDTH (AMOUNT_WIDTH)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_req    (in_req),
    .in_amount (in_amount),
    .cmd_valid (f_valid),
    .cmd_ready (f_ready),
    .cmd       (f_cmd)
  );

  // Hold commands while the result side stalls
  tda_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (f_valid),
    .push_ready (f_ready),
    .push_data  (f_cmd),
    .pop_valid  (q_valid),
    .pop_ready  (q_ready),
    .pop_data   (q_cmd)
  );

  // Update the stored time and drive the result register
  tda_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd_valid (q_valid),
    .cmd_ready (q_ready),
    .cmd       (q_cmd),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_rsp   (out_rsp)
  );

endmodule

`default_nettype wire

// ===== design/tda_monitor.sv =====
// Port-level assertions for the time-of-day block and their bind.
`timescale 1ns / 1ps
`default_nettype none

module tda_monitor (
  input logic          clk,
  input logic          rst_n,
  input logic          out_valid,
  input logic          out_ready,
  input tda_pkg::rsp_t out_rsp
);

  // Hold a stalled result
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_rsp))
    else $error("result changed while stalled");

  a_time_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_rsp.hour_now < 5'd24 && out_rsp.minute_now < 6'd60
                  && out_rsp.second_now < 6'd60)
    else $error("time of day out of range");

  a_flags_excl: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_rsp.is_less && out_rsp.is_equal))
    else $error("less and equal both set");

  a_equal_diff: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_rsp.is_equal |-> out_rsp.difference == 17'd0)
    else $error("equal times with nonzero difference");

  a_diff_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_rsp.difference < 17'd86400)
    else $error("difference beyond one day");

endmodule

bind time_of_day_arithmetic tda_monitor u_tda_monitor (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_rsp   (out_rsp)
);

`default_nettype wire

// ===== tb/tb_top.sv =====
// Self-checking testbench for the time-of-day arithmetic block.
`timescale 1ns / 1ps

module tb_top;

  // Amount port width used for this run
  localparam int AMT_W = 32;

  // Time base, kept as plain unsigned integers so predictor arithmetic is 32-bit
  localparam int unsigned DAY_S  = 86400;
  localparam int unsigned HOUR_S = 3600;
  localparam int unsigned MIN_S  = 60;
  localparam int unsigned MAX_H  = 24;

  // Run control
  localparam int RANDOM_BLOCKS   = 12;
  localparam int BLOCK_ITEMS     = 100;
  localparam int DRAIN_CYCLES    = 40;      // well past the block's latency
  localparam int CYCLE_LIMIT     = 200000;  // watchdog limit for the whole run
  localparam int MAX_PRINTED     = 50;

  logic                clk;
  logic                rst_n;
  logic                in_valid;
  logic                in_ready;
  tda_pkg::in_req_t    in_req;
  logic [AMT_W-1:0]    in_amount;
  logic                out_valid;
  logic                out_ready;
  tda_pkg::rsp_t       out_rsp;

  // Predicted time of day, advanced once per accepted request
  logic [4:0]          tod_hour;
  logic [5:0]          tod_minute;
  logic [5:0]          tod_second;

  // Results the block still owes, oldest first
  tda_pkg::rsp_t       pending_rsp_q[$];

  // Bookkeeping
  int                  mismatch_count;
  int                  results_checked;
  int                  requests_taken;
  int                  action_count[4];
  int                  cycle_count;
  bit                  burst_mode;       // no gaps and no stalls while set

  time_of_day_arithmetic #(
    .AMOUNT_WIDTH(AMT_W)
  ) u_top (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_req   (in_req),
    .in_amount(in_amount),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_rsp  (out_rsp)
  );

  // 2 ns clock
  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Watchdog: end the run if the block stops making progress
  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("Timeout after %0d cycles, %0d results still pending",
             cycle_count, pending_rsp_q.size());
    $display("** time_of_day_arithmetic: FAILED **");
    $finish;
  end

  // Print one line per mismatch (up to a cap) and count every one
  task automatic report_mismatch(string msg);
    mismatch_count++;
    if (mismatch_count <= MAX_PRINTED)
      $display("MISMATCH @%0t result %0d: %s", $realtime, results_checked, msg);
  endtask

  task automatic check_field(string field, logic [16:0] got, logic [16:0] want);
    if (got !== want)
      report_mismatch($sformatf("%s got %0d want %0d", field, got, want));
  endtask

  // Split seconds-of-day into the stored hour/minute/second
  function automatic void load_seconds_of_day(int unsigned t);
    tod_hour   = 5'(t / HOUR_S);
    tod_minute = 6'((t / MIN_S) % MIN_S);
    tod_second = 6'(t % MIN_S);
  endfunction

  // Apply one request to the predicted clock and return the result it owes
  function automatic tda_pkg::rsp_t apply_request(tda_pkg::in_req_t req,
                                                  logic [AMT_W-1:0] amt);
    int unsigned   now_s;
    int unsigned   step_s;
    int unsigned   opnd_s;
    tda_pkg::rsp_t rsp;
    rsp    = '0;
    now_s  = tod_hour * HOUR_S + tod_minute * MIN_S + tod_second;
    step_s = int'(amt % DAY_S);
    case (req.action)
      tda_pkg::ACT_SET: begin
        // Out-of-range fields load zero, each on its own
        tod_hour   = (req.operand_hour   < MAX_H) ? req.operand_hour   : 5'd0;
        tod_minute = (req.operand_minute < MIN_S) ? req.operand_minute : 6'd0;
        tod_second = (req.operand_second < MIN_S) ? req.operand_second : 6'd0;
      end
      tda_pkg::ACT_ADD: load_seconds_of_day((now_s + step_s) % DAY_S);
      tda_pkg::ACT_SUB: load_seconds_of_day((now_s + DAY_S - step_s) % DAY_S);
      default: begin
        // Ordering looks at the raw operand fields, hour first
        opnd_s = (req.operand_hour * HOUR_S + req.operand_minute * MIN_S +
                  req.operand_second) % DAY_S;
        rsp.is_equal = (tod_hour == req.operand_hour) &&
                       (tod_minute == req.operand_minute) &&
                       (tod_second == req.operand_second);
        if (tod_hour != req.operand_hour)
          rsp.is_less = tod_hour < req.operand_hour;
        else if (tod_minute != req.operand_minute)
          rsp.is_less = tod_minute < req.operand_minute;
        else
          rsp.is_less = tod_second < req.operand_second;
        rsp.difference = 17'((now_s + DAY_S - opnd_s) % DAY_S);
      end
    endcase
    rsp.hour_now   = tod_hour;
    rsp.minute_now = tod_minute;
    rsp.second_now = tod_second;
    return rsp;
  endfunction

  // Monitor: predict on every accepted request, check every accepted result.
  // Values are sampled at the rising edge, before the block updates them.
  always @(posedge clk) begin
    tda_pkg::rsp_t want;
    if (rst_n) begin
      if (in_valid && in_ready) begin
        pending_rsp_q.push_back(apply_request(in_req, in_amount));
        requests_taken++;
        action_count[in_req.action]++;
      end
      if (out_valid && out_ready) begin
        if (pending_rsp_q.size() == 0) begin
          report_mismatch("result with no pending request");
        end else begin
          want = pending_rsp_q.pop_front();
          check_field("hour_now",   17'(out_rsp.hour_now),   17'(want.hour_now));
          check_field("minute_now", 17'(out_rsp.minute_now), 17'(want.minute_now));
          check_field("second_now", 17'(out_rsp.second_now), 17'(want.second_now));
          check_field("is_less",    17'(out_rsp.is_less),    17'(want.is_less));
          check_field("is_equal",   17'(out_rsp.is_equal),   17'(want.is_equal));
          check_field("difference", out_rsp.difference,      want.difference);
        end
        results_checked++;
      end
    end
  end

  // Result side: random stalls before taking each result, none in burst mode.
  // Changes land on the falling edge so they are settled before the block samples them.
  initial begin
    int unsigned stall;
    out_ready = 1'b0;
    wait (rst_n === 1'b1);
    @(negedge clk);
    forever begin
      stall = burst_mode ? 0 : $urandom_range(0, 9);
      if (stall != 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!(out_valid === 1'b1 && out_ready === 1'b1));
      @(negedge clk);
    end
  end

  // Send one request. Enter and leave on a falling edge; hold valid and the
  // payload steady until the block takes the request.
  task automatic send_req(tda_pkg::action_t act, logic [AMT_W-1:0] amt,
                          logic [4:0] hr, logic [5:0] mn, logic [5:0] sc);
    int unsigned gap;
    gap = burst_mode ? 0 : $urandom_range(0, 9);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid  <= 1'b1;
    in_req    <= '{action: act, operand_hour: hr, operand_minute: mn,
                   operand_second: sc};
    in_amount <= amt;
    do @(posedge clk); while (!(in_valid && in_ready));
    @(negedge clk);
  endtask

  // Reset state, then loads at the edges and with out-of-range fields
  task automatic test_set_and_clamp();
    send_req(tda_pkg::ACT_CMP, '0, 5'd0, 6'd0, 6'd0);        // reset time is midnight
    send_req(tda_pkg::ACT_SET, '0, 5'd23, 6'd59, 6'd59);
    send_req(tda_pkg::ACT_SET, '0, 5'd24, 6'd60, 6'd60);     // all three just out of range
    send_req(tda_pkg::ACT_SET, '0, 5'd31, 6'd63, 6'd63);
    send_req(tda_pkg::ACT_SET, '0, 5'd5, 6'd61, 6'd7);       // only the minute clamps
    send_req(tda_pkg::ACT_SET, '0, 5'd0, 6'd0, 6'd0);
  endtask

  // Wrap across midnight both ways, whole days and the largest amounts
  task automatic test_add_subtract_wrap();
    send_req(tda_pkg::ACT_SET, '0, 5'd23, 6'd59, 6'd59);
    send_req(tda_pkg::ACT_ADD, 32'd1, 5'd0, 6'd0, 6'd0);
    send_req(tda_pkg::ACT_SUB, 32'd1, 5'd0, 6'd0, 6'd0);
    send_req(tda_pkg::ACT_ADD, 32'd86400, 5'd0, 6'd0, 6'd0);
    send_req(tda_pkg::ACT_ADD, 32'hFFFF_FFFF, 5'd31, 6'd63, 6'd63);
    send_req(tda_pkg::ACT_SUB, 32'hFFFF_FFFF, 5'd31, 6'd63, 6'd63);
    send_req(tda_pkg::ACT_SUB, 32'd86399, 5'd0, 6'd0, 6'd0);
    send_req(tda_pkg::ACT_ADD, 32'd0, 5'd0, 6'd0, 6'd0);
    send_req(tda_pkg::ACT_SUB, 32'd0, 5'd0, 6'd0, 6'd0);
  endtask

  // Ordering on each field, equality, and operands outside a normal day
  task automatic test_compare_order();
    send_req(tda_pkg::ACT_SET, '0, 5'd12, 6'd30, 6'd30);
    send_req(tda_pkg::ACT_CMP, '0, 5'd12, 6'd30, 6'd30);
    send_req(tda_pkg::ACT_CMP, '0, 5'd13, 6'd0, 6'd0);
    send_req(tda_pkg::ACT_CMP, '0, 5'd11, 6'd59, 6'd59);
    send_req(tda_pkg::ACT_CMP, '0, 5'd12, 6'd31, 6'd0);
    send_req(tda_pkg::ACT_CMP, '0, 5'd12, 6'd30, 6'd31);
    send_req(tda_pkg::ACT_CMP, '0, 5'd12, 6'd30, 6'd29);
    send_req(tda_pkg::ACT_CMP, 32'hFFFF_FFFF, 5'd31, 6'd63, 6'd63);
    send_req(tda_pkg::ACT_CMP, '0, 5'd24, 6'd0, 6'd0);       // operand total wraps to zero
  endtask

  // Mixed random traffic; every fourth block runs with no gaps or stalls
  task automatic test_random_traffic();
    tda_pkg::action_t act;
    logic [AMT_W-1:0] amt;
    logic [4:0]       hr;
    logic [5:0]       mn;
    logic [5:0]       sc;
    int unsigned      pick;
    for (int blk = 0; blk < RANDOM_BLOCKS; blk++) begin
      burst_mode = (blk % 4 == 3);
      for (int i = 0; i < BLOCK_ITEMS; i++) begin
        act = tda_pkg::action_t'($urandom_range(0, 3));
        // Amounts: half small or within a day, some near whole days, some wide
        pick = $urandom_range(0, 9);
        if (pick < 3)
          amt = $urandom_range(0, 200);
        else if (pick < 5)
          amt = $urandom_range(0, DAY_S - 1);
        else if (pick < 7)
          amt = $urandom_range(0, 49710) * DAY_S + $urandom_range(0, 2) - 1;
        else
          amt = $urandom;
        // Operands: mostly a legal time, a quarter anywhere in the field range
        if ($urandom_range(0, 3) == 0) begin
          hr = 5'($urandom_range(0, 31));
          mn = 6'($urandom_range(0, 63));
          sc = 6'($urandom_range(0, 63));
        end else begin
          hr = 5'($urandom_range(0, MAX_H - 1));
          mn = 6'($urandom_range(0, MIN_S - 1));
          sc = 6'($urandom_range(0, MIN_S - 1));
        end
        // Compare against the current time or one step away from it
        if (act == tda_pkg::ACT_CMP && $urandom_range(0, 3) == 0) begin
          hr = tod_hour;
          mn = tod_minute;
          sc = tod_second;
          case ($urandom_range(0, 3))
            1: hr = hr + 5'd1;
            2: mn = mn - 6'd1;
            3: sc = sc + 6'd1;
            default: ;
          endcase
        end
        send_req(act, amt, hr, mn, sc);
      end
    end
    burst_mode = 1'b0;
  endtask

  initial begin
    rst_n           = 1'b0;
    in_valid        = 1'b0;
    in_req          = '0;
    in_amount       = '0;
    burst_mode      = 1'b0;
    mismatch_count  = 0;
    results_checked = 0;
    requests_taken  = 0;
    action_count    = '{default: 0};
    tod_hour        = '0;
    tod_minute      = '0;
    tod_second      = '0;

    // Hold reset, then release on a falling edge
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_set_and_clamp();
    test_add_subtract_wrap();
    test_compare_order();
    test_random_traffic();

    // Drop valid, wait for every owed result, then let the pipe drain
    in_valid <= 1'b0;
    while (pending_rsp_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Ran %0d requests (%0d set, %0d add, %0d subtract, %0d compare), %0d results",
             requests_taken, action_count[tda_pkg::ACT_SET],
             action_count[tda_pkg::ACT_ADD], action_count[tda_pkg::ACT_SUB],
             action_count[tda_pkg::ACT_CMP], results_checked);
    $display("Used %0d cycles with random gaps and stalls; %0d mismatches seen",
             cycle_count, mismatch_count);
    if (mismatch_count == 0) begin
      $display("** time_of_day_arithmetic: PASSED **");
    end else begin
      $display("** time_of_day_arithmetic: FAILED **");
    end
    $finish;
  end

endmodule
